@@ sv/lnsp_pkg.sv @@
// Package for the loop nest sampling profiler.
// Holds the mode and status codes, the controller states and the command
// and status structs shared by the controller, the datapath and the top level.
`default_nettype none

package lnsp_pkg;

    localparam int ID_W       = 8;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int OUT_CNT_W  = 32;
    localparam int DEPTH_W    = 7;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - OUT_CNT_W - DEPTH_W;

    localparam logic [ID_W-1:0] TOP_CONTEXT = 8'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENTER = 2'd0,
        MODE_EXIT  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DISCARD  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_TOP      = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ENTER,
        S_EXIT,
        S_READ,
        S_TICK_RS,
        S_TICK_RC,
        S_TICK_UP,
        S_CLR_RS,
        S_CLR_WR,
        S_TICK_DONE
    } t_state;

    typedef enum logic [1:0] {
        SR_TOP,
        SR_BELOW,
        SR_WALK
    } t_stk_sel;

    typedef enum logic [1:0] {
        CA_IN,
        CA_ID,
        CA_STK
    } t_cnt_sel;

    typedef struct packed {
        logic     take_in;
        logic     walk_rst;
        logic     walk_inc;
        logic     clr_disc;
        logic     set_disc;
        logic     push;
        logic     pop;
        logic     init_wr;
        logic     cnt_inc;
        logic     flag_clr;
        logic     load_out;
        logic     load_cnt;
        t_status  out_status;
        t_stk_sel stk_sel;
        t_cnt_sel cnt_sel;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic sp_zero;
        logic sp_one;
        logic full;
        logic top_match;
        logic top_ctx;
        logic walk_last;
        logic discarded;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ sv/loop_nest_sampling_profiler.sv @@
// Loop nest sampling profiler, top level. An exit discards non-matching stack
// entries one at a time until it stops; a tick walks the stack once to count,
// reading each entry, reading its counter and updating it, and once more to
// clear the tick flags, reading each entry and writing its flag.
// A result waits in an output register while the next beat is taken.
// After reset a clearing pass over NUM_LOOPS entries zeroes the counters and
// flags; no beat is accepted until it ends. The stack holds context 0 alone.
`default_nettype none

module loop_nest_sampling_profiler #(
    parameter int NUM_LOOPS   = 256,
    parameter int STACK_DEPTH = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] loop_id
    input  wire  [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // [2:0] status, [34:3] count_value,
                                        // [41:35] stack_depth, [47:42] zero
);
    import lnsp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lnsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (t_mode'(s_axis_tuser)),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    lnsp_datapath #(
        .NUM_LOOPS   (NUM_LOOPS),
        .STACK_DEPTH (STACK_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !stat.full)
        else $error("push issued onto a full stack");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result register overwritten before it was taken");

    a_push_leaves_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> !stat.sp_zero)
        else $error("stack empty after a push");

    a_no_accept_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !cmd.cnt_inc && !cmd.flag_clr)
        else $error("beat accepted during a tick walk");
`endif

endmodule

`default_nettype wire

@@ sv/lnsp_ctrl.sv @@
// Controller state machine of the loop nest sampling profiler.
// Sequences enter, exit, tick and read beats and the counter clearing pass.
// Depends on lnsp_pkg.
`default_nettype none

module lnsp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  lnsp_pkg::t_mode  i_in_mode,
    input  lnsp_pkg::t_stat  i_stat,
    output lnsp_pkg::t_cmd   o_cmd,
    output logic             o_in_ready
);
    import lnsp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_mode)
                        MODE_ENTER: n_state = S_ENTER;
                        MODE_EXIT:  n_state = S_EXIT;
                        MODE_READ:  n_state = S_READ;
                        MODE_TICK:  n_state = i_stat.sp_zero ? S_TICK_DONE : S_TICK_RS;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ENTER, S_READ, S_TICK_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EXIT: begin
                priority if (i_stat.sp_zero || i_stat.top_match || i_stat.top_ctx
                             || i_stat.sp_one) begin
                    if (i_stat.out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_EXIT;
                end
            end
            S_TICK_RS: n_state = S_TICK_RC;
            S_TICK_RC: n_state = S_TICK_UP;
            S_TICK_UP: n_state = i_stat.walk_last ? S_CLR_RS : S_TICK_RS;
            S_CLR_RS:  n_state = S_CLR_WR;
            S_CLR_WR:  n_state = i_stat.walk_last ? S_TICK_DONE : S_CLR_RS;
            default:   n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = ST_OK;
        o_cmd.stk_sel    = SR_TOP;
        o_cmd.cnt_sel    = CA_ID;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.take_in  = i_in_valid;
                o_cmd.walk_rst = 1'b1;
                o_cmd.clr_disc = 1'b1;
                o_cmd.cnt_sel  = CA_IN;
            end
            S_ENTER: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.out_status = ST_OVERFLOW;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
            end
            S_EXIT: begin
                priority if (i_stat.sp_zero) begin
                    o_cmd.load_out   = i_stat.out_free;
                    o_cmd.out_status = ST_EMPTY;
                end else if (i_stat.top_match) begin
                    o_cmd.load_out   = i_stat.out_free;
                    o_cmd.pop        = i_stat.out_free;
                    o_cmd.out_status = i_stat.discarded ? ST_DISCARD : ST_OK;
                end else if (i_stat.top_ctx) begin
                    o_cmd.load_out   = i_stat.out_free;
                    o_cmd.out_status = ST_TOP;
                end else if (i_stat.sp_one) begin
                    o_cmd.load_out   = i_stat.out_free;
                    o_cmd.pop        = i_stat.out_free;
                    o_cmd.out_status = ST_EMPTY;
                end else begin
                    o_cmd.pop      = 1'b1;
                    o_cmd.set_disc = 1'b1;
                    o_cmd.stk_sel  = SR_BELOW;
                end
            end
            S_READ: begin
                o_cmd.load_out = i_stat.out_free;
                o_cmd.load_cnt = i_stat.out_free;
            end
            S_TICK_RS, S_CLR_RS: begin
                o_cmd.stk_sel = SR_WALK;
            end
            S_TICK_RC: begin
                o_cmd.stk_sel = SR_WALK;
                o_cmd.cnt_sel = CA_STK;
            end
            S_TICK_UP: begin
                o_cmd.stk_sel  = SR_WALK;
                o_cmd.cnt_sel  = CA_STK;
                o_cmd.cnt_inc  = 1'b1;
                o_cmd.walk_inc = 1'b1;
                o_cmd.walk_rst = i_stat.walk_last;
            end
            S_CLR_WR: begin
                o_cmd.stk_sel  = SR_WALK;
                o_cmd.cnt_sel  = CA_STK;
                o_cmd.flag_clr = 1'b1;
                o_cmd.walk_inc = 1'b1;
            end
            S_TICK_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd.init_wr = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/lnsp_datapath.sv @@
// Datapath of the loop nest sampling profiler: loop stack memory, stack
// pointer, counter and tick flag memories, walk and clear indexes, and the
// result register. Depends on lnsp_pkg.
`default_nettype none

module lnsp_datapath #(
    parameter int NUM_LOOPS   = 256,
    parameter int STACK_DEPTH = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [lnsp_pkg::IN_DATA_W-1:0]     i_in_data,
    input  lnsp_pkg::t_cmd                     i_cmd,
    input  wire                                i_out_ready,
    output lnsp_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output logic [lnsp_pkg::OUT_DATA_W-1:0]    o_out_data
);
    import lnsp_pkg::*;

    localparam int LA  = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS) : 1;
    localparam int SA  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = ((LA > ID_W) ? LA : ID_W) + 1;

    function automatic logic [LA-1:0] id_addr(input logic [ID_W-1:0] id);
        logic [IW-1:0] ext;
        ext = IW'(id);
        return ext[LA-1:0];
    endfunction

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return IW'(id) < IW'(NUM_LOOPS);
    endfunction

    logic [ID_W-1:0]        stk_mem  [STACK_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem  [NUM_LOOPS];
    logic                   flag_mem [NUM_LOOPS];

    logic [ID_W-1:0]        r_id;
    logic [SPW-1:0]         r_sp;
    logic [SPW-1:0]         n_sp;
    logic                   r_disc;
    logic [SA-1:0]          r_walk;
    logic [LA-1:0]          r_init;
    logic [ID_W-1:0]        r_stk_rd;
    logic [COUNT_WIDTH-1:0] r_cnt_rd;
    logic                   r_flag_rd;
    logic                   r_out_valid;
    t_status                r_status;
    logic [OUT_CNT_W-1:0]   r_count;
    logic [DEPTH_W-1:0]     r_depth;

    logic [SA-1:0]          stk_rd_addr;
    logic                   stk_we;
    logic [SA-1:0]          stk_wr_addr;
    logic [ID_W-1:0]        stk_wr_data;
    logic [ID_W-1:0]        cnt_id;
    logic [LA-1:0]          stk_cnt_addr;
    logic                   stk_id_ok;
    logic                   cnt_we;
    logic                   flag_we;
    logic [LA-1:0]          cnt_wr_addr;
    logic [COUNT_WIDTH-1:0] cnt_wr_data;
    logic                   flag_wr_data;
    logic [COUNT_WIDTH-1:0] cnt_sat;
    logic [63:0]            cnt_wide;
    logic [15:0]            sp_wide;
    logic                   out_free;

    // Stack memory: push port, plus the top context written during the clearing pass.
    always_comb begin
        unique case (i_cmd.stk_sel)
            SR_TOP:   stk_rd_addr = SA'(r_sp - SPW'(1));
            SR_BELOW: stk_rd_addr = SA'(r_sp - SPW'(2));
            SR_WALK:  stk_rd_addr = r_walk;
            default:  stk_rd_addr = r_walk;
        endcase
        stk_we      = i_cmd.push || (i_cmd.init_wr && (r_init == '0));
        stk_wr_addr = i_cmd.push ? SA'(r_sp) : '0;
        stk_wr_data = i_cmd.push ? r_id : TOP_CONTEXT;
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        r_stk_rd <= stk_mem[stk_rd_addr];
    end

    // Counter and tick flag memories.
    always_comb begin
        unique case (i_cmd.cnt_sel)
            CA_IN:   cnt_id = i_in_data[ID_W-1:0];
            CA_ID:   cnt_id = r_id;
            CA_STK:  cnt_id = r_stk_rd;
            default: cnt_id = r_id;
        endcase
        stk_cnt_addr = id_addr(r_stk_rd);
        stk_id_ok    = id_in_range(r_stk_rd);
        cnt_sat      = (r_cnt_rd == '1) ? r_cnt_rd : r_cnt_rd + COUNT_WIDTH'(1);
        cnt_we       = i_cmd.init_wr || (i_cmd.cnt_inc && stk_id_ok && !r_flag_rd);
        flag_we      = cnt_we || (i_cmd.flag_clr && stk_id_ok);
        cnt_wr_addr  = i_cmd.init_wr ? r_init : stk_cnt_addr;
        cnt_wr_data  = i_cmd.init_wr ? '0 : cnt_sat;
        flag_wr_data = i_cmd.cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        r_cnt_rd <= cnt_mem[id_addr(cnt_id)];
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            flag_mem[cnt_wr_addr] <= flag_wr_data;
        end
        r_flag_rd <= flag_mem[id_addr(cnt_id)];
    end

    always_comb begin
        priority if (i_cmd.push) begin
            n_sp = r_sp + SPW'(1);
        end else if (i_cmd.pop) begin
            n_sp = r_sp - SPW'(1);
        end else begin
            n_sp = r_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= SPW'(1);
            r_disc <= 1'b0;
            r_walk <= '0;
            r_init <= '0;
        end else begin
            r_sp <= n_sp;
            if (i_cmd.clr_disc) begin
                r_disc <= 1'b0;
            end else if (i_cmd.set_disc) begin
                r_disc <= 1'b1;
            end
            if (i_cmd.walk_rst) begin
                r_walk <= '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + SA'(1);
            end
            if (i_cmd.init_wr) begin
                r_init <= r_init + LA'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_id <= i_in_data[ID_W-1:0];
        end
    end

    // Result register.
    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_wide = 64'(r_cnt_rd);
    assign sp_wide  = 16'(n_sp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= i_cmd.out_status;
            r_count  <= (i_cmd.load_cnt && id_in_range(r_id)) ? cnt_wide[OUT_CNT_W-1:0] : '0;
            r_depth  <= sp_wide[DEPTH_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{OUT_PAD_W{1'b0}}, r_depth, r_count, r_status};

    always_comb begin
        o_stat.init_last = (r_init == LA'(NUM_LOOPS - 1));
        o_stat.sp_zero   = (r_sp == '0);
        o_stat.sp_one    = (r_sp == SPW'(1));
        o_stat.full      = (r_sp == SPW'(STACK_DEPTH));
        o_stat.top_match = (r_stk_rd == r_id);
        o_stat.top_ctx   = (r_stk_rd == TOP_CONTEXT) && (r_id != TOP_CONTEXT);
        o_stat.walk_last = ((SPW'(r_walk) + SPW'(1)) == r_sp);
        o_stat.discarded = r_disc;
        o_stat.out_free  = out_free;
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for loop_nest_sampling_profiler: a directed table and then random
// enter, exit, tick and read beats, checked by table rows or an in-bench profiler model.
// Depends on lnsp_pkg and loop_nest_sampling_profiler from the RTL.
`timescale 1ns / 1ps

module tb_top;

    import lnsp_pkg::*;

    localparam int STACK_CAP   = 64;
    localparam int ID_SPACE    = 256;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_BEATS  = 2000;
    localparam int TAIL_CYCLES = 400;
    localparam int LONG_HOLD   = 300;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        t_status     status;
        logic [31:0] count;
        logic [6:0]  depth;
    } t_prof_result;

    typedef struct packed {
        t_mode        mode;
        logic [7:0]   id;
        logic         fixed;
        t_prof_result res;
    } t_dir_row;

    localparam t_prof_result NO_RES = '{ST_OK, 32'd0, 7'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] loop_id
    logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [2:0] status, [34:3] count_value,
                                         // [41:35] stack_depth, [47:42] zero

    logic [7:0]  loop_ids [0:STACK_CAP-1];
    int          stack_fill;
    logic [31:0] hit_counts [0:ID_SPACE-1];
    int          status_tally [0:7];
    int          tick_beats;

    t_prof_result pending_results [$];
    int          beats_sent;
    int          results_seen;
    int          err_count;
    longint      cycles;
    bit          quiet;
    bit          hold_req;
    int          rx_wait;

    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{MODE_READ,  8'd0,   1'b1, '{ST_OK,    32'd0, 7'd1}},
        '{MODE_READ,  8'd255, 1'b1, '{ST_OK,    32'd0, 7'd1}},
        '{MODE_EXIT,  8'd7,   1'b1, '{ST_TOP,   32'd0, 7'd1}},
        '{MODE_ENTER, 8'd255, 1'b1, '{ST_OK,    32'd0, 7'd2}},
        '{MODE_ENTER, 8'd1,   1'b1, '{ST_OK,    32'd0, 7'd3}},
        '{MODE_TICK,  8'd0,   1'b0, NO_RES},
        '{MODE_READ,  8'd255, 1'b0, NO_RES},
        '{MODE_ENTER, 8'd5,   1'b0, NO_RES},
        '{MODE_ENTER, 8'd5,   1'b0, NO_RES},
        '{MODE_TICK,  8'd33,  1'b0, NO_RES},
        '{MODE_READ,  8'd5,   1'b0, NO_RES},
        '{MODE_EXIT,  8'd255, 1'b0, NO_RES},
        '{MODE_ENTER, 8'd4,   1'b0, NO_RES},
        '{MODE_ENTER, 8'd6,   1'b0, NO_RES},
        '{MODE_EXIT,  8'd9,   1'b0, NO_RES},
        '{MODE_EXIT,  8'd0,   1'b0, NO_RES},
        '{MODE_EXIT,  8'd0,   1'b1, '{ST_EMPTY, 32'd0, 7'd0}},
        '{MODE_TICK,  8'd255, 1'b0, NO_RES},
        '{MODE_READ,  8'd0,   1'b0, NO_RES},
        '{MODE_ENTER, 8'd170, 1'b0, NO_RES},
        '{MODE_EXIT,  8'd85,  1'b0, NO_RES},
        '{MODE_ENTER, 8'd0,   1'b0, NO_RES},
        '{MODE_ENTER, 8'd128, 1'b0, NO_RES},
        '{MODE_EXIT,  8'd0,   1'b0, NO_RES},
        '{MODE_ENTER, 8'd0,   1'b0, NO_RES}
    };

    loop_nest_sampling_profiler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_prof_result profile_step(input t_mode m, input logic [7:0] id);
        t_prof_result r;
        bit [ID_SPACE-1:0] seen;
        bit discarded;
        bit done;
        r = NO_RES;
        seen = '0;
        discarded = 1'b0;
        done = 1'b0;
        case (m)
            MODE_ENTER: begin
                if (stack_fill >= STACK_CAP) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    loop_ids[stack_fill] = id;
                    stack_fill++;
                end
            end
            MODE_EXIT: begin
                while (!done) begin
                    if (stack_fill == 0) begin
                        r.status = ST_EMPTY;
                        done = 1'b1;
                    end else if (loop_ids[stack_fill-1] == id) begin
                        stack_fill--;
                        r.status = discarded ? ST_DISCARD : ST_OK;
                        done = 1'b1;
                    end else if (loop_ids[stack_fill-1] == TOP_CONTEXT && id != TOP_CONTEXT) begin
                        r.status = ST_TOP;
                        done = 1'b1;
                    end else begin
                        stack_fill--;
                        discarded = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                tick_beats++;
                for (int i = 0; i < stack_fill; i++) begin
                    if (!seen[loop_ids[i]]) begin
                        if (hit_counts[loop_ids[i]] != 32'hFFFF_FFFF) begin
                            hit_counts[loop_ids[i]]++;
                        end
                        seen[loop_ids[i]] = 1'b1;
                    end
                end
            end
            default: begin
                r.count = hit_counts[id];
            end
        endcase
        r.depth = stack_fill[6:0];
        status_tally[r.status]++;
        return r;
    endfunction

    task automatic send_beat(input t_mode m, input logic [7:0] id, input logic fixed,
                             input t_prof_result fixed_res);
        int gap;
        t_prof_result res;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= id;
        do @(posedge i_clk); while (!s_axis_tready);
        res = profile_step(m, id);
        pending_results.insert(pending_results.size(), fixed ? fixed_res : res);
        beats_sent++;
    endtask

    function automatic logic [7:0] pick_id();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            return 8'($urandom_range(1, 15));
        end else if (sel < 80) begin
            return TOP_CONTEXT;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_stacked_id();
        if (stack_fill > 0 && $urandom_range(0, 99) < 70) begin
            return loop_ids[$urandom_range(0, stack_fill - 1)];
        end
        return pick_id();
    endfunction

    task automatic check_result(input logic [47:0] beat);
        t_prof_result want;
        t_prof_result got;
        got = '{t_status'(beat[2:0]), beat[34:3], beat[41:35]};
        results_seen++;
        if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing pending, actual %h", $time, beat);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
                err_count++;
            end
            if (got.count != want.count) begin
                $display("%0t: count_value mismatch, expected %0d actual %0d",
                         $time, want.count, got.count);
                err_count++;
            end
            if (got.depth != want.depth) begin
                $display("%0t: stack_depth mismatch, expected %0d actual %0d",
                         $time, want.depth, got.depth);
                err_count++;
            end
            if (beat[47:42] != 6'd0) begin
                $display("%0t: padding mismatch, expected 0 actual %h", $time, beat[47:42]);
                err_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                rx_wait = quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("loop_nest_sampling_profiler verification failed");
            $finish;
        end
    end

    initial begin
        int sel;
        int rand_sent;
        bit hold_done;
        bit pause_done;
        stack_fill = 1;
        loop_ids[0] = TOP_CONTEXT;
        for (int i = 0; i < ID_SPACE; i++) hit_counts[i] = 32'd0;
        for (int i = 0; i < 8; i++) status_tally[i] = 0;
        tick_beats = 0;
        beats_sent = 0;
        results_seen = 0;
        err_count = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        rand_sent = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_beat(dir_rows[r].mode, dir_rows[r].id, dir_rows[r].fixed, dir_rows[r].res);
        end

        while (rand_sent < RAND_BEATS) begin
            if (!hold_done && rand_sent >= 300) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && rand_sent >= 900) begin
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
                pause_done = 1'b1;
            end
            quiet = (rand_sent >= 1300 && rand_sent < 1500);
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                while (stack_fill < STACK_CAP) send_beat(MODE_ENTER, 8'($urandom), 1'b0, NO_RES);
                repeat (2) send_beat(MODE_ENTER, 8'($urandom), 1'b0, NO_RES);
            end else if (sel < 5) begin
                while (stack_fill > 0) send_beat(MODE_EXIT, TOP_CONTEXT, 1'b0, NO_RES);
                send_beat(MODE_EXIT, 8'($urandom), 1'b0, NO_RES);
                send_beat(MODE_ENTER, TOP_CONTEXT, 1'b0, NO_RES);
            end else if (sel < 10) begin
                send_beat(t_mode'($urandom_range(0, 3)), 8'($urandom), 1'b0, NO_RES);
            end else if (sel < 15) begin
                send_beat(MODE_TICK, 8'($urandom), 1'b0, NO_RES);
            end else if (sel < 50) begin
                send_beat(MODE_ENTER, pick_id(), 1'b0, NO_RES);
            end else if (sel < 75) begin
                send_beat(MODE_EXIT, pick_stacked_id(), 1'b0, NO_RES);
            end else begin
                send_beat(MODE_READ, pick_stacked_id(), 1'b0, NO_RES);
            end
            rand_sent = beats_sent - DIR_ROWS;
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats, checked %0d results, %0d of them sample ticks.",
                 beats_sent, results_seen, tick_beats);
        $display("Overflows %0d, discarding exits %0d, top-context stops %0d, empty exits %0d.",
                 status_tally[ST_OVERFLOW], status_tally[ST_DISCARD],
                 status_tally[ST_TOP], status_tally[ST_EMPTY]);
        if (err_count == 0) begin
            $display("loop_nest_sampling_profiler verification clean");
        end else begin
            $display("loop_nest_sampling_profiler verification failed");
        end
        $finish;
    end

endmodule
